FILE: rtl/pscs_pkg.sv
// Shared types and constants for the per-channel scale and shift unit.
// Used by pscs_seq, per_channel_scale_shift_unit and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pscs_pkg;

    // Default sizing of the coefficient store and the fixed-point format.
    localparam int MAX_CHANNELS_DEFAULT  = 256;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // Blocked layout groups channels in blocks of eight lanes.
    localparam int BLOCK_LANES   = 8;
    localparam int LANE_SEL_BITS = 3;

    // Field and register widths.
    localparam int DATA_BITS      = 32;
    localparam int CHAN_FIELD_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;
    localparam int CCOUNT_BITS    = 9;
    localparam int ELEMS_BITS     = 17;
    localparam int BATCH_BITS     = 16;
    localparam int ELEM_POS_BITS  = 16;

    // Largest element count per channel; larger settings clamp to it.
    localparam logic [ELEMS_BITS-1:0] ELEM_LIMIT = 17'd65536;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LAYOUT         = 3'd0,
        REG_CHANNEL_COUNT  = 3'd1,
        REG_ELEMENTS       = 3'd2,
        REG_BATCH_COUNT    = 3'd3,
        REG_ALPHA_PRESENT  = 3'd4,
        REG_BETA_PRESENT   = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        LAYOUT_CHANNEL_MAJOR = 2'd0,
        LAYOUT_INTERLEAVED   = 2'd1,
        LAYOUT_BLOCKED       = 2'd2
    } layout_t;

    // Per-sample control from the position sequencer to the datapath.
    typedef struct packed {
        logic tensor_end;
        logic alpha_on;
        logic beta_on;
    } seq_flags_t;

endpackage

FILE: rtl/pscs_seq.sv
// Configuration registers and tensor position counters of the scale and shift unit.
// Depends on pscs_pkg for register codes, layout codes and the flag struct.
`timescale 1ns / 1ps

module pscs_seq #(
    parameter int MAX_CHANNELS = pscs_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pscs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pscs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 step,
    output logic [$clog2(MAX_CHANNELS)-1:0]      channel,
    output pscs_pkg::seq_flags_t                 flags
);

    localparam int CW = $clog2(MAX_CHANNELS);
    localparam int BW = (CW > pscs_pkg::LANE_SEL_BITS) ? CW - pscs_pkg::LANE_SEL_BITS : 1;

    logic [1:0]                            layout_reg;
    logic [pscs_pkg::CCOUNT_BITS-1:0]      ccount_reg;
    logic [pscs_pkg::ELEMS_BITS-1:0]       elems_reg;
    logic [pscs_pkg::BATCH_BITS-1:0]       batches_reg;
    logic                                  alpha_on_reg;
    logic                                  beta_on_reg;

    logic [CW-1:0]                         lane_reg, lane_next;
    logic [pscs_pkg::ELEM_POS_BITS-1:0]    elem_reg, elem_next;
    logic [BW-1:0]                         block_reg, block_next;
    logic [pscs_pkg::BATCH_BITS-1:0]       batch_reg, batch_next;

    logic [CW-1:0]                         chan_last;
    logic [CW:0]                           chans_w;
    logic [CW:0]                           blocks_w;
    logic [BW-1:0]                         block_last;
    logic [pscs_pkg::ELEM_POS_BITS-1:0]    elem_last;
    logic [pscs_pkg::BATCH_BITS-1:0]       batch_last;
    logic [CW-1:0]                         lane_last;
    logic                                  lane_wrap, elem_wrap, block_wrap, batch_wrap;
    logic                                  is_blocked;
    logic                                  last_sample;

    // Effective counts: zero acts as one, oversized counts clamp.
    always_comb
    begin
        if (ccount_reg == '0)
            chan_last = '0;
        else if (32'(ccount_reg) > 32'(MAX_CHANNELS))
            chan_last = CW'(MAX_CHANNELS - 1);
        else
            chan_last = CW'(ccount_reg - 9'd1);

        chans_w  = (CW+1)'(chan_last) + (CW+1)'(1);
        blocks_w = chans_w >> pscs_pkg::LANE_SEL_BITS;
        if (blocks_w == '0)
            block_last = '0;
        else
            block_last = BW'(blocks_w - (CW+1)'(1));

        if (elems_reg == '0)
            elem_last = '0;
        else if (elems_reg > pscs_pkg::ELEM_LIMIT)
            elem_last = pscs_pkg::ELEM_POS_BITS'(pscs_pkg::ELEM_LIMIT - 17'd1);
        else
            elem_last = pscs_pkg::ELEM_POS_BITS'(elems_reg - 17'd1);

        if (batches_reg == '0)
            batch_last = '0;
        else
            batch_last = batches_reg - 16'd1;
    end

    assign is_blocked = (layout_reg == pscs_pkg::LAYOUT_BLOCKED);
    assign lane_last  = is_blocked ? CW'(pscs_pkg::BLOCK_LANES - 1) : chan_last;

    assign lane_wrap  = (lane_reg == lane_last);
    assign elem_wrap  = (elem_reg == elem_last);
    assign block_wrap = (block_reg == block_last);
    assign batch_wrap = (batch_reg == batch_last);

    // The innermost counter always moves; each outer one moves when all inner ones wrap.
    always_comb
    begin
        lane_next   = lane_reg;
        elem_next   = elem_reg;
        block_next  = block_reg;
        batch_next  = batch_reg;
        last_sample = 1'b0;
        case (layout_reg)
            pscs_pkg::LAYOUT_INTERLEAVED:
            begin
                lane_next = lane_wrap ? '0 : lane_reg + CW'(1);
                if (lane_wrap)
                    elem_next = elem_wrap ? '0 : elem_reg + 16'd1;
                if (lane_wrap && elem_wrap)
                    batch_next = batch_wrap ? '0 : batch_reg + 16'd1;
                last_sample = lane_wrap && elem_wrap && batch_wrap;
            end
            pscs_pkg::LAYOUT_BLOCKED:
            begin
                lane_next = lane_wrap ? '0 : lane_reg + CW'(1);
                if (lane_wrap)
                    elem_next = elem_wrap ? '0 : elem_reg + 16'd1;
                if (lane_wrap && elem_wrap)
                    block_next = block_wrap ? '0 : block_reg + BW'(1);
                if (lane_wrap && elem_wrap && block_wrap)
                    batch_next = batch_wrap ? '0 : batch_reg + 16'd1;
                last_sample = lane_wrap && elem_wrap && block_wrap && batch_wrap;
            end
            default:
            begin
                elem_next = elem_wrap ? '0 : elem_reg + 16'd1;
                if (elem_wrap)
                    lane_next = lane_wrap ? '0 : lane_reg + CW'(1);
                if (elem_wrap && lane_wrap)
                    batch_next = batch_wrap ? '0 : batch_reg + 16'd1;
                last_sample = elem_wrap && lane_wrap && batch_wrap;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg   <= pscs_pkg::LAYOUT_CHANNEL_MAJOR;
            ccount_reg   <= 9'd1;
            elems_reg    <= 17'd1;
            batches_reg  <= 16'd1;
            alpha_on_reg <= 1'b0;
            beta_on_reg  <= 1'b0;
            lane_reg     <= '0;
            elem_reg     <= '0;
            block_reg    <= '0;
            batch_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pscs_pkg::REG_LAYOUT:        layout_reg   <= cfg_data[1:0];
                pscs_pkg::REG_CHANNEL_COUNT: ccount_reg   <= cfg_data[pscs_pkg::CCOUNT_BITS-1:0];
                pscs_pkg::REG_ELEMENTS:      elems_reg    <= cfg_data;
                pscs_pkg::REG_BATCH_COUNT:   batches_reg  <= cfg_data[pscs_pkg::BATCH_BITS-1:0];
                pscs_pkg::REG_ALPHA_PRESENT: alpha_on_reg <= cfg_data[0];
                pscs_pkg::REG_BETA_PRESENT:  beta_on_reg  <= cfg_data[0];
                default:                     ;
            endcase
            // Any write to a defined register restarts the tensor.
            if (cfg_index inside {pscs_pkg::REG_LAYOUT, pscs_pkg::REG_CHANNEL_COUNT,
                                  pscs_pkg::REG_ELEMENTS, pscs_pkg::REG_BATCH_COUNT,
                                  pscs_pkg::REG_ALPHA_PRESENT, pscs_pkg::REG_BETA_PRESENT})
            begin
                lane_reg  <= '0;
                elem_reg  <= '0;
                block_reg <= '0;
                batch_reg <= '0;
            end
        end
        else if (step)
        begin
            lane_reg  <= lane_next;
            elem_reg  <= elem_next;
            block_reg <= block_next;
            batch_reg <= batch_next;
        end
    end

    // In the blocked layout the lane stays below eight, so the channel is a concatenation.
    assign channel = is_blocked ? CW'({block_reg, lane_reg[pscs_pkg::LANE_SEL_BITS-1:0]})
                                : lane_reg;

    assign flags.tensor_end = last_sample;
    assign flags.alpha_on   = alpha_on_reg;
    assign flags.beta_on    = beta_on_reg;

endmodule

FILE: rtl/per_channel_scale_shift_unit.sv
// Top level of the per-channel scale and shift unit: coefficient memories and datapath.
// Depends on pscs_pkg and instantiates pscs_seq.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries two kinds of items. A load item
// (operation = load) writes alpha_value and beta_value for coef_channel into the
// coefficient memories and produces no output. A sample item yields one output
// transfer: scaled = alpha[c] * sample + beta[c] in signed Q16.16, with the
// product rounded half up and the sum saturated, plus the channel used and a
// tensor_end flag on the last sample of the tensor.
// The configuration channel (cfg_valid/cfg_ready) is always ready; each write to a
// defined register restarts the tensor position counters. Write it only while the
// unit is idle. Throughput is one item per cycle unless out_ready stalls the output.
// A sample's result is presented after four register stages: the memory read, the
// 32x32 multiply, the rounding shift and the add with saturation.
// A load takes effect for any sample transferred after it.
// When out_ready is low, results collect in the stage registers, and in_ready
// drops only once every stage holds a sample, so up to four results are in flight.
// Reset clears counters, configuration and pipeline valids. The coefficient
// memories are not cleared; load every channel that a tensor uses first.
module per_channel_scale_shift_unit #(
    parameter int MAX_CHANNELS  = pscs_pkg::MAX_CHANNELS_DEFAULT,
    parameter int FRACTION_BITS = pscs_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pscs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pscs_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic [pscs_pkg::CHAN_FIELD_BITS-1:0]  coef_channel,
    input  logic signed [pscs_pkg::DATA_BITS-1:0] alpha_value,
    input  logic signed [pscs_pkg::DATA_BITS-1:0] beta_value,
    input  logic signed [pscs_pkg::DATA_BITS-1:0] sample,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pscs_pkg::DATA_BITS-1:0] scaled,
    output logic [pscs_pkg::CHAN_FIELD_BITS-1:0]  channel_used,
    output logic                                  tensor_end
);

    localparam int CW = $clog2(MAX_CHANNELS);
    localparam int DW = pscs_pkg::DATA_BITS;
    localparam int PW = 2 * DW;

    // Scale of one in the fixed-point format, and the rounding offset of half an LSB.
    localparam logic signed [DW-1:0] ALPHA_ONE  = DW'(64'd1 << FRACTION_BITS);
    localparam logic signed [PW-1:0] ROUND_HALF =
        (FRACTION_BITS == 0) ? 64'd0 : (64'd1 << (FRACTION_BITS - 1));

    // Coefficient memories, one entry per channel, one write and one read port each.
    logic [DW-1:0] alpha_mem [MAX_CHANNELS];
    logic [DW-1:0] beta_mem  [MAX_CHANNELS];

    logic                  in_xfer;
    logic                  coef_we;
    logic                  sample_take;
    logic [CW-1:0]         coef_addr;
    logic [CW-1:0]         seq_channel;
    pscs_pkg::seq_flags_t  seq_flags;

    // Stage 1: memory read data and the sample.
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_chan_reg;
    pscs_pkg::seq_flags_t  s1_flags_reg;
    logic signed [DW-1:0]  s1_sample_reg;
    logic signed [DW-1:0]  alpha_rd_reg;
    logic signed [DW-1:0]  beta_rd_reg;
    logic signed [DW-1:0]  alpha_op;
    logic signed [DW-1:0]  beta_op;

    // Stage 2: full product.
    logic                  s2_valid_reg;
    logic [CW-1:0]         s2_chan_reg;
    logic                  s2_end_reg;
    logic signed [DW-1:0]  s2_beta_reg;
    logic signed [PW-1:0]  s2_prod_reg;
    logic signed [PW-1:0]  prod_next;

    // Stage 3: rounded product.
    logic                  s3_valid_reg;
    logic [CW-1:0]         s3_chan_reg;
    logic                  s3_end_reg;
    logic signed [DW-1:0]  s3_beta_reg;
    logic signed [PW-1:0]  s3_round_reg;
    logic signed [PW-1:0]  round_next;

    // Output stage.
    logic                  out_valid_reg;
    logic signed [DW-1:0]  scaled_reg;
    logic [CW-1:0]         chan_out_reg;
    logic                  end_out_reg;
    logic [PW:0]           sum_wide;
    logic signed [DW-1:0]  scaled_next;
    logic                  sat_high;
    logic                  sat_low;

    logic                  s1_ready, s2_ready, s3_ready, out_stage_ready;

    // Each stage accepts when it is empty or its content moves on this cycle.
    assign out_stage_ready = !out_valid_reg || out_ready;
    assign s3_ready        = !s3_valid_reg || out_stage_ready;
    assign s2_ready        = !s2_valid_reg || s3_ready;
    assign s1_ready        = !s1_valid_reg || s2_ready;

    assign in_ready  = s1_ready;
    assign cfg_ready = 1'b1;

    assign in_xfer     = in_valid && in_ready;
    assign sample_take = in_xfer && (operation == pscs_pkg::OP_SAMPLE);
    // Loads to channels beyond the memory are dropped.
    assign coef_we     = in_xfer && (operation == pscs_pkg::OP_LOAD)
                         && (32'(coef_channel) < 32'(MAX_CHANNELS));
    assign coef_addr   = CW'(coef_channel);

    pscs_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (sample_take),
        .channel   (seq_channel),
        .flags     (seq_flags)
    );

    // A sample reads its coefficients at its own transfer edge. A load writes at its
    // transfer edge, so a sample that follows in the next cycle already sees the new
    // entry and no forwarding path is needed. The read registers hold while stalled.
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            alpha_mem[coef_addr] <= alpha_value;
            beta_mem[coef_addr]  <= beta_value;
        end
        if (sample_take)
        begin
            alpha_rd_reg  <= alpha_mem[seq_channel];
            beta_rd_reg   <= beta_mem[seq_channel];
            s1_sample_reg <= sample;
            s1_chan_reg   <= seq_channel;
            s1_flags_reg  <= seq_flags;
        end
    end

    // Absent tables stand for a scale of one and a shift of zero.
    assign alpha_op = s1_flags_reg.alpha_on ? alpha_rd_reg : ALPHA_ONE;
    assign beta_op  = s1_flags_reg.beta_on ? beta_rd_reg : '0;

    assign prod_next = alpha_op * s1_sample_reg;

    // Round half up: add half an LSB, then shift arithmetically (floor).
    assign round_next = (s2_prod_reg + ROUND_HALF) >>> FRACTION_BITS;

    // Add the shift in one extra bit and clamp to the signed 32-bit range.
    assign sum_wide = {s3_round_reg[PW-1], s3_round_reg}
                      + {{(PW-DW+1){s3_beta_reg[DW-1]}}, s3_beta_reg};
    assign sat_high = !sum_wide[PW] && (|sum_wide[PW-1:DW-1]);
    assign sat_low  = sum_wide[PW] && !(&sum_wide[PW-1:DW-1]);

    always_comb
    begin
        if (sat_high)
            scaled_next = {1'b0, {(DW-1){1'b1}}};
        else if (sat_low)
            scaled_next = {1'b1, {(DW-1){1'b0}}};
        else
            scaled_next = sum_wide[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= prod_next;
            s2_beta_reg <= beta_op;
            s2_chan_reg <= s1_chan_reg;
            s2_end_reg  <= s1_flags_reg.tensor_end;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_round_reg <= round_next;
            s3_beta_reg  <= s2_beta_reg;
            s3_chan_reg  <= s2_chan_reg;
            s3_end_reg   <= s2_end_reg;
        end
        if (out_stage_ready && s3_valid_reg)
        begin
            scaled_reg   <= scaled_next;
            chan_out_reg <= s3_chan_reg;
            end_out_reg  <= s3_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= sample_take;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_stage_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scaled       = scaled_reg;
    assign channel_used = pscs_pkg::CHAN_FIELD_BITS'(chan_out_reg);
    assign tensor_end   = end_out_reg;

endmodule

FILE: tb/tb_per_channel_scale_shift_unit.sv
// Self-checking testbench for the per-channel scale and shift unit.
// Drives load and sample transfers under random stalls and checks every result
// against its own predictor; depends on pscs_pkg and per_channel_scale_shift_unit.
`timescale 1ns / 1ps

module tb_per_channel_scale_shift_unit;

    localparam int TABLE_DEPTH   = pscs_pkg::MAX_CHANNELS_DEFAULT;
    localparam int FRAC          = pscs_pkg::FRACTION_BITS_DEFAULT;
    localparam int DW            = pscs_pkg::DATA_BITS;
    localparam int CHW           = pscs_pkg::CHAN_FIELD_BITS;
    localparam int IXW           = pscs_pkg::CFG_INDEX_BITS;
    localparam int CDW           = pscs_pkg::CFG_DATA_BITS;
    // Cycles to let pass after the last result before the unit counts as idle.
    localparam int LATENCY_SLACK = 8;

    // Register indexes past the end of the list; writes to them are dropped.
    localparam logic [IXW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IXW-1:0] REG_SPARE_HI = 3'd7;
    // The unused layout code, which behaves like channel-major.
    localparam logic [1:0] LAYOUT_UNDEFINED = 2'd3;

    // What happens halfway through a phase.
    localparam int PAUSE_NONE        = 0;
    localparam int PAUSE_DRAIN       = 1;
    localparam int PAUSE_DRAIN_SPARE = 2;

    typedef struct {
        logic signed [DW-1:0]  scaled;
        logic [CHW-1:0]        channel;
        logic                  end_flag;
    } scaled_result_t;

    // Predicts alpha[c] * x + beta[c] for each sample transfer and holds the
    // results still owed by the unit, oldest first.
    class scale_shift_scoreboard;
        logic [DW-1:0] alpha_tbl [TABLE_DEPTH];
        logic [DW-1:0] beta_tbl  [TABLE_DEPTH];
        bit            loaded    [TABLE_DEPTH];

        logic [1:0]                       layout_reg;
        logic [pscs_pkg::CCOUNT_BITS-1:0] chan_reg;
        logic [pscs_pkg::ELEMS_BITS-1:0]  elem_reg;
        logic [pscs_pkg::BATCH_BITS-1:0]  batch_reg;
        logic                             alpha_on;
        logic                             beta_on;

        int unsigned lane_pos;
        int unsigned elem_pos;
        int unsigned block_pos;
        int unsigned batch_pos;

        scaled_result_t pending_outputs [$];
        int             failures;

        function new();
            foreach (loaded[i])
                loaded[i] = 1'b0;
            layout_reg = pscs_pkg::LAYOUT_CHANNEL_MAJOR;
            chan_reg   = pscs_pkg::CCOUNT_BITS'(1);
            elem_reg   = pscs_pkg::ELEMS_BITS'(1);
            batch_reg  = pscs_pkg::BATCH_BITS'(1);
            alpha_on   = 1'b0;
            beta_on    = 1'b0;
            failures   = 0;
            restart();
        endfunction

        function void restart();
            lane_pos  = 0;
            elem_pos  = 0;
            block_pos = 0;
            batch_pos = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned active_channels();
            return clamp(32'(chan_reg), 1, TABLE_DEPTH);
        endfunction

        // Number of table entries a tensor can touch under the current setting.
        function int unsigned channels_in_use();
            int unsigned blocks;
            if (layout_reg != pscs_pkg::LAYOUT_BLOCKED)
                return active_channels();
            blocks = active_channels() / pscs_pkg::BLOCK_LANES;
            if (blocks == 0)
                blocks = 1;
            return blocks * pscs_pkg::BLOCK_LANES;
        endfunction

        // Moves a position counter on by one; true when it wraps to zero.
        function bit step_wraps(inout int unsigned pos, input int unsigned limit);
            if (pos + 1 >= limit)
            begin
                pos = 0;
                return 1'b1;
            end
            pos = pos + 1;
            return 1'b0;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            failures++;
        endtask

        function void apply_register(logic [IXW-1:0] idx, logic [CDW-1:0] data);
            case (idx)
                pscs_pkg::REG_LAYOUT:        layout_reg = data[1:0];
                pscs_pkg::REG_CHANNEL_COUNT: chan_reg   = data[pscs_pkg::CCOUNT_BITS-1:0];
                pscs_pkg::REG_ELEMENTS:      elem_reg   = data[pscs_pkg::ELEMS_BITS-1:0];
                pscs_pkg::REG_BATCH_COUNT:   batch_reg  = data[pscs_pkg::BATCH_BITS-1:0];
                pscs_pkg::REG_ALPHA_PRESENT: alpha_on   = data[0];
                pscs_pkg::REG_BETA_PRESENT:  beta_on    = data[0];
                default:                     return;
            endcase
            restart();
        endfunction

        function void note_item(pscs_pkg::op_t op, logic [CHW-1:0] ch,
                                logic signed [DW-1:0] a,
                                logic signed [DW-1:0] b,
                                logic signed [DW-1:0] x);
            int unsigned    chans;
            int unsigned    elems;
            int unsigned    batches;
            int unsigned    blocks;
            int unsigned    channel;
            longint         coef_a;
            longint         coef_b;
            longint         sum;
            bit             wrapped;
            scaled_result_t res;

            // A load only writes the tables; the counters stay where they are.
            if (op == pscs_pkg::OP_LOAD)
            begin
                alpha_tbl[ch] = a;
                beta_tbl[ch]  = b;
                loaded[ch]    = 1'b1;
                return;
            end

            chans   = active_channels();
            elems   = clamp(32'(elem_reg), 1, 65536);
            batches = clamp(32'(batch_reg), 1, 65535);

            if (layout_reg == pscs_pkg::LAYOUT_BLOCKED)
            begin
                blocks = chans / pscs_pkg::BLOCK_LANES;
                if (blocks == 0)
                    blocks = 1;
                channel = block_pos * pscs_pkg::BLOCK_LANES + lane_pos;
            end
            else
            begin
                blocks  = 1;
                channel = lane_pos;
            end
            if (channel >= TABLE_DEPTH)
                channel = 0;

            coef_a = alpha_on ? longint'($signed(alpha_tbl[channel]))
                              : (longint'(1) <<< FRAC);
            coef_b = beta_on  ? longint'($signed(beta_tbl[channel])) : longint'(0);
            // Round half up: add half an LSB, then floor by arithmetic shift.
            sum = ((coef_a * longint'(x) + (longint'(1) <<< (FRAC - 1))) >>> FRAC)
                  + coef_b;
            if (sum > longint'(32'sh7FFFFFFF))
                sum = longint'(32'sh7FFFFFFF);
            if (sum < longint'(32'sh80000000))
                sum = longint'(32'sh80000000);

            // Innermost counter first; each outer one moves only on a wrap.
            wrapped = 1'b0;
            if (layout_reg == pscs_pkg::LAYOUT_INTERLEAVED)
            begin
                if (step_wraps(lane_pos, chans))
                    if (step_wraps(elem_pos, elems))
                        wrapped = step_wraps(batch_pos, batches);
            end
            else if (layout_reg == pscs_pkg::LAYOUT_BLOCKED)
            begin
                if (step_wraps(lane_pos, pscs_pkg::BLOCK_LANES))
                    if (step_wraps(elem_pos, elems))
                        if (step_wraps(block_pos, blocks))
                            wrapped = step_wraps(batch_pos, batches);
            end
            else
            begin
                if (step_wraps(elem_pos, elems))
                    if (step_wraps(lane_pos, chans))
                        wrapped = step_wraps(batch_pos, batches);
            end

            res.scaled   = sum[DW-1:0];
            res.channel  = channel[CHW-1:0];
            res.end_flag = wrapped;
            pending_outputs.push_back(res);
        endfunction

        task check_result(logic signed [DW-1:0] s, logic [CHW-1:0] c, logic e);
            scaled_result_t want;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("result %h ch %0d with nothing pending", s, c));
                return;
            end
            want = pending_outputs.pop_front();
            if (s !== want.scaled)
                report($sformatf("scaled %h, predicted %h", s, want.scaled));
            if (c !== want.channel)
                report($sformatf("channel_used %0d, predicted %0d", c, want.channel));
            if (e !== want.end_flag)
                report($sformatf("tensor_end %b, predicted %b", e, want.end_flag));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IXW-1:0]         cfg_index = '0;
    logic [CDW-1:0]         cfg_data  = '0;

    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   operation    = pscs_pkg::OP_LOAD;
    logic [CHW-1:0]         coef_channel = '0;
    logic signed [DW-1:0]   alpha_value  = '0;
    logic signed [DW-1:0]   beta_value   = '0;
    logic signed [DW-1:0]   sample       = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [DW-1:0]   scaled;
    logic [CHW-1:0]         channel_used;
    logic                   tensor_end;

    scale_shift_scoreboard board;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;

    per_channel_scale_shift_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .coef_channel (coef_channel),
        .alpha_value  (alpha_value),
        .beta_value   (beta_value),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scaled       (scaled),
        .channel_used (channel_used),
        .tensor_end   (tensor_end)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Coefficients: extremes, small values between minus four and four, or any bit pattern.
    function automatic logic signed [DW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3, 4, 5, 6: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return 32'shFFFF8000;
            4, 5, 6: return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
            default: return $urandom;
        endcase
    endfunction

    // Fills the bits above a register's width with random junk.
    function automatic logic [CDW-1:0] with_noise(logic [CDW-1:0] value, int w);
        logic [CDW-1:0] junk;
        junk = CDW'($urandom);
        return value | (junk & ~((17'd1 << w) - 17'd1));
    endfunction

    // Receiver: checks each output transfer and stalls out_ready at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                board.check_result(scaled, channel_used, tensor_end);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                          : $urandom_range(1, 3);
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Presents one item and returns at the edge of its transfer with in_valid
    // still high, so a back-to-back item never drops valid for a step.
    task automatic send_item(pscs_pkg::op_t op, logic [CHW-1:0] ch,
                             logic signed [DW-1:0] a,
                             logic signed [DW-1:0] b,
                             logic signed [DW-1:0] x);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        coef_channel <= ch;
        alpha_value  <= a;
        beta_value   <= b;
        sample       <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(op, ch, a, b, x);
    endtask

    task automatic send_random_item(int load_pct);
        if ($urandom_range(0, 99) < load_pct)
            send_item(pscs_pkg::OP_LOAD, CHW'($urandom_range(0, 255)), pick_coef(),
                      pick_coef(), $urandom);
        else
            send_item(pscs_pkg::OP_SAMPLE, CHW'($urandom_range(0, 255)), pick_coef(),
                      pick_coef(), pick_sample());
    endtask

    // Stops sending and waits until every owed result has come back, then waits out
    // LATENCY_SLACK as well so that trailing loads have landed too.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    // Leaves cfg_valid high on return; the caller lowers it after the last write.
    task automatic write_register(logic [IXW-1:0] idx, logic [CDW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.apply_register(idx, data);
    endtask

    // Writes all six registers, then, if either table is present, loads every table
    // entry the new setting can read that has never been written.
    task automatic program_unit(logic [1:0] lay, int cc, int elems, int batch,
                                bit ap, bit bp);
        int unsigned in_use;
        write_register(pscs_pkg::REG_LAYOUT,        with_noise(17'(lay), 2));
        write_register(pscs_pkg::REG_CHANNEL_COUNT,
                       with_noise(17'(cc), pscs_pkg::CCOUNT_BITS));
        write_register(pscs_pkg::REG_ELEMENTS,      17'(elems));
        write_register(pscs_pkg::REG_BATCH_COUNT,
                       with_noise(17'(batch), pscs_pkg::BATCH_BITS));
        write_register(pscs_pkg::REG_ALPHA_PRESENT, with_noise(17'(ap), 1));
        write_register(pscs_pkg::REG_BETA_PRESENT,  with_noise(17'(bp), 1));
        cfg_valid <= 1'b0;
        if (ap || bp)
        begin
            in_use = board.channels_in_use();
            for (int ch = 0; ch < in_use; ch++)
                if (!board.loaded[ch])
                    send_item(pscs_pkg::OP_LOAD, CHW'(ch), pick_coef(), pick_coef(),
                              $urandom);
        end
    endtask

    task automatic run_phase(logic [1:0] lay, int cc, int elems, int batch, bit ap, bit bp,
                             int count, int load_pct, int pause_mode);
        settle();
        program_unit(lay, cc, elems, batch, ap, bp);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && pause_mode != PAUSE_NONE)
            begin
                settle();
                // An out-of-range register write must not restart the tensor.
                if (pause_mode == PAUSE_DRAIN_SPARE)
                begin
                    write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                                   CDW'($urandom));
                    cfg_valid <= 1'b0;
                end
            end
            send_random_item(load_pct);
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [1:0] lay;
        int         cc;

        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset the unit scales by one and adds zero, and every sample
        // is a complete tensor.
        send_item(pscs_pkg::OP_SAMPLE, CHW'($urandom_range(0, 255)), $urandom, $urandom,
                  32'sh7FFFFFFF);
        send_item(pscs_pkg::OP_SAMPLE, CHW'($urandom_range(0, 255)), $urandom, $urandom,
                  32'sh80000000);

        // Rounding: alpha of one LSB makes the product a pure fraction.
        settle();
        program_unit(pscs_pkg::LAYOUT_CHANNEL_MAJOR, 1, 1, 1, 1'b1, 1'b1);
        send_item(pscs_pkg::OP_LOAD, 8'd0, 32'sh00000001, 32'sh0, $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh00008000);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'shFFFF8000);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh00007FFF);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'shFFFF7FFF);

        // Saturation at both ends, including the product of the two minimums
        // and minus one times the most negative sample.
        send_item(pscs_pkg::OP_LOAD, 8'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh7FFFFFFF);
        send_item(pscs_pkg::OP_LOAD, 8'd0, 32'sh80000000, 32'sh80000000, $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh7FFFFFFF);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh80000000);
        send_item(pscs_pkg::OP_LOAD, 8'd0, 32'shFFFF0000, 32'sh0, $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, 32'sh80000000);

        // Loads between samples take effect at once and leave the counters alone.
        settle();
        program_unit(pscs_pkg::LAYOUT_INTERLEAVED, 3, 1, 1, 1'b1, 1'b1);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, pick_sample());
        send_item(pscs_pkg::OP_LOAD, 8'd1, pick_coef(), pick_coef(), $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, pick_sample());
        send_item(pscs_pkg::OP_LOAD, 8'd255, pick_coef(), pick_coef(), $urandom);
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, pick_sample());
        send_item(pscs_pkg::OP_SAMPLE, 8'd0, $urandom, $urandom, pick_sample());

        // Settings at the edges of each register's range.
        run_phase(LAYOUT_UNDEFINED, 2, 2, 2, 1'b1, 1'b0, 12, 10, PAUSE_NONE);
        run_phase(pscs_pkg::LAYOUT_INTERLEAVED, 0, 0, 0, 1'b0, 1'b1, 8, 10, PAUSE_NONE);
        run_phase(pscs_pkg::LAYOUT_INTERLEAVED, 511, 1, 1, 1'b0, 1'b0, 260, 0,
                  PAUSE_DRAIN_SPARE);
        run_phase(pscs_pkg::LAYOUT_BLOCKED, 13, 131071, 65535, 1'b1, 1'b1, 16, 10,
                  PAUSE_NONE);
        run_phase(pscs_pkg::LAYOUT_BLOCKED, 5, 2, 2, 1'b1, 1'b0, 24, 10, PAUSE_DRAIN);
        run_phase(pscs_pkg::LAYOUT_CHANNEL_MAJOR, 256, 65536, 65535, 1'b0, 1'b0, 8, 10,
                  PAUSE_NONE);
        run_phase(pscs_pkg::LAYOUT_BLOCKED, 16, 1, 2, 1'b0, 1'b1, 20, 10,
                  PAUSE_DRAIN_SPARE);

        // Small random tensors, so that tensor_end comes round often.
        for (int p = 0; p < 3; p++)
        begin
            lay = 2'($urandom_range(0, 3));
            if (lay == pscs_pkg::LAYOUT_BLOCKED && $urandom_range(0, 1))
                cc = pscs_pkg::BLOCK_LANES * $urandom_range(1, 3);
            else
                cc = $urandom_range(1, 12);
            run_phase(lay, cc, $urandom_range(1, 4), $urandom_range(1, 3),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(6, 12), 15,
                      $urandom_range(0, 2) == 0 ? PAUSE_DRAIN_SPARE : PAUSE_NONE);
        end

        settle();
        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
